>>> rtl/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0] START_BYTE     = 8'h99;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
  localparam logic [8:0] RECORD_HEADER  = 9'd7;
  // Header bytes plus the trailing record checksum.
  localparam logic [8:0] RECORD_EXTRA   = 9'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_A   = 2'd1;
  localparam logic [1:0] ST_BAD_B   = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  source_port;
    logic [31:0] time_now;
  } in_t;

  typedef struct packed {
    logic [63:0] record_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic [1:0]  frame_status;
  } out_t;

endpackage

>>> rtl/sfd_ram.sv
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/serial_frame_deframer_log_record_unit.sv
// Serial frame deframer that turns checked frames into log records.
// Input channel (in_valid/in_ready/in_item): one received byte per request,
// with its source port and the current 100 us time. The parser hunts for
// 0x99, takes a length byte L (payload is L-4 bytes), stores the payload
// and checks two running sums (A += byte, B += A, both seeded with L).
// Output channel (out_valid/out_ready/out_item): a good frame becomes a
// record of L+4 bytes (0x99, payload length, source, time LE, payload,
// 8-bit sum of all bytes after 0x99), packed 8 bytes per word, last_word
// on the final one. A bad length or checksum gives one error word
// (byte_count 0, status code) instead.
// Throughput: one input byte per cycle while parsing, unless a held output
// word stalls a length or checksum byte. After checksum B the record is
// read back from the payload RAM one byte per cycle while the receiver
// takes words, with a RAM read bubble after each word; in_ready stays low.
// A waiting output word only blocks bytes that could produce a result
// (length and checksum bytes); a stalled receiver freezes record readout.
// Reset (rst, synchronous) returns the parser to hunting; the payload RAM
// is not cleared, as every entry is written by a frame before it is read.
module serial_frame_deframer_log_record_unit #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfd_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output sfd_pkg::out_t out_item
);

  import sfd_pkg::*;

  localparam int         AW      = $clog2(MAX_PAYLOAD);
  localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN,
    PH_DATA,
    PH_SUMA,
    PH_SUMB,
    PH_EMIT
  } phase_t;

  phase_t      phase;
  logic [7:0]  expected_length;
  logic [7:0]  payload_index;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [31:0] frame_time;
  logic [1:0]  frame_source;
  logic [7:0]  chk;          // record checksum, built while parsing

  // Record readout: r is the next byte to issue, pend is the byte in flight
  // through the RAM read stage, word_buf collects one output word.
  logic [8:0]  r;
  logic        pend;
  logic [8:0]  pend_idx;
  logic        pend_ram;
  logic [7:0]  pend_byte;
  logic [63:0] word_buf;
  logic        full;
  logic [3:0]  word_cnt;
  logic        word_last;

  logic        ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;

  logic        out_free;
  logic        in_acc;
  logic [7:0]  c;
  logic [7:0]  len8;
  logic [8:0]  len_ext;
  logic [8:0]  total;
  logic [8:0]  r_off;
  logic        pend_last;
  logic        move;
  logic        can_issue;
  logic [7:0]  land_byte;
  logic [7:0]  issue_byte;
  logic [7:0]  sum_a_next;
  logic [7:0]  sum_b_next;

  assign out_free = !out_valid || out_ready;
  // Waiting and payload bytes never produce a result, so they go on
  // even while an output word is held.
  assign in_ready = (phase != PH_EMIT) &&
                    (out_free || phase == PH_WAIT || phase == PH_DATA);
  assign in_acc   = in_valid && in_ready;
  assign c        = in_item.data_byte;
  assign len8     = c - FRAME_OVERHEAD;
  assign len_ext  = {1'b0, c} - {1'b0, FRAME_OVERHEAD};

  assign sum_a_next = sum_a + c;
  assign sum_b_next = sum_b + sum_a_next;

  assign total     = {1'b0, expected_length} + RECORD_EXTRA;
  assign r_off     = r - RECORD_HEADER;
  assign ram_raddr = r_off[AW-1:0];
  assign pend_last = pend && (pend_idx[2:0] == 3'd7 || pend_idx == total - 9'd1);
  assign move      = full && out_free;
  assign can_issue = (phase == PH_EMIT) && (r < total) && (!full || move) && !pend_last;
  assign land_byte = pend_ram ? ram_rdata : pend_byte;

  // Payload is written only while parsing and read only during readout,
  // so a write and a read of one entry never overlap.
  assign ram_we = in_acc && phase == PH_DATA;

  always_comb begin
    issue_byte = 8'h00;
    if (r == total - 9'd1) begin
      issue_byte = chk;
    end else begin
      unique case (r[2:0])
        3'd0:    issue_byte = START_BYTE;
        3'd1:    issue_byte = expected_length;
        3'd2:    issue_byte = {6'b0, frame_source};
        3'd3:    issue_byte = frame_time[7:0];
        3'd4:    issue_byte = frame_time[15:8];
        3'd5:    issue_byte = frame_time[23:16];
        3'd6:    issue_byte = frame_time[31:24];
        default: issue_byte = 8'h00;
      endcase
    end
  end

  sfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload (
    .clk   (clk),
    .we    (ram_we),
    .waddr (payload_index[AW-1:0]),
    .wdata (c),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      expected_length <= '0;
      payload_index   <= '0;
      sum_a           <= '0;
      sum_b           <= '0;
      frame_time      <= '0;
      frame_source    <= '0;
      chk             <= '0;
      r               <= '0;
      pend            <= 1'b0;
      pend_idx        <= '0;
      pend_ram        <= 1'b0;
      pend_byte       <= '0;
      word_buf        <= '0;
      full            <= 1'b0;
      word_cnt        <= '0;
      word_last       <= 1'b0;
      out_valid       <= 1'b0;
      out_item        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (phase)
        PH_LEN: begin
          if (in_acc) begin
            if (c < FRAME_OVERHEAD || len_ext > MAX_LEN) begin
              out_valid <= 1'b1;
              out_item  <= '{record_word: '0, byte_count: '0, last_word: 1'b1,
                             frame_status: ST_BAD_LEN};
              phase     <= PH_WAIT;
            end else begin
              expected_length <= len8;
              sum_a           <= c;
              sum_b           <= c;
              payload_index   <= '0;
              chk             <= len8 + {6'b0, frame_source} + frame_time[7:0] +
                                 frame_time[15:8] + frame_time[23:16] + frame_time[31:24];
              phase           <= (len8 == 8'd0) ? PH_SUMA : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (in_acc) begin
            sum_a         <= sum_a_next;
            sum_b         <= sum_b_next;
            chk           <= chk + c;
            payload_index <= payload_index + 8'd1;
            if ({1'b0, payload_index} + 9'd1 >= {1'b0, expected_length}) begin
              phase <= PH_SUMA;
            end
          end
        end
        PH_SUMA: begin
          if (in_acc) begin
            if (c != sum_a) begin
              out_valid <= 1'b1;
              out_item  <= '{record_word: '0, byte_count: '0, last_word: 1'b1,
                             frame_status: ST_BAD_A};
              phase     <= PH_WAIT;
            end else begin
              phase <= PH_SUMB;
            end
          end
        end
        PH_SUMB: begin
          if (in_acc) begin
            if (c != sum_b) begin
              out_valid <= 1'b1;
              out_item  <= '{record_word: '0, byte_count: '0, last_word: 1'b1,
                             frame_status: ST_BAD_B};
              phase     <= PH_WAIT;
            end else begin
              r        <= '0;
              pend     <= 1'b0;
              full     <= 1'b0;
              word_buf <= '0;
              phase    <= PH_EMIT;
            end
          end
        end
        PH_EMIT: begin
          // Hand a finished word to the output register.
          if (move) begin
            out_valid <= 1'b1;
            out_item  <= '{record_word: word_buf, byte_count: word_cnt,
                           last_word: word_last, frame_status: ST_OK};
            word_buf  <= '0;
            full      <= 1'b0;
          end
          // Land the byte that left the RAM stage.
          if (pend) begin
            word_buf[pend_idx[2:0]*8 +: 8] <= land_byte;
            word_cnt  <= {1'b0, pend_idx[2:0]} + 4'd1;
            word_last <= (pend_idx == total - 9'd1);
            if (pend_last) begin
              full <= 1'b1;
            end
          end
          // Issue the next byte.
          pend <= can_issue;
          if (can_issue) begin
            pend_idx  <= r;
            pend_ram  <= (r >= RECORD_HEADER) && (r != total - 9'd1);
            pend_byte <= issue_byte;
            r         <= r + 9'd1;
          end
          if (r == total && !pend && !full) begin
            phase <= PH_WAIT;
          end
        end
        default: begin
          phase <= PH_WAIT;
          if (in_acc && c == START_BYTE) begin
            frame_time   <= in_item.time_now;
            frame_source <= in_item.source_port;
            phase        <= PH_LEN;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A full word buffer never has a byte in flight behind it.
  assert property (@(posedge clk) disable iff (rst) full |-> !pend)
    else $error("readout byte in flight while word buffer full");

  // Readout never runs past the end of the record.
  assert property (@(posedge clk) disable iff (rst) pend |-> (pend_idx < total))
    else $error("readout index beyond record length");

  // An error word is always a single, empty, final word.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_status != ST_OK) |->
      (out_item.byte_count == 4'd0 && out_item.last_word && out_item.record_word == '0))
    else $error("malformed error word");

  // No new request is taken while a record is being read out.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT && !(r == total && !pend && !full)) |=> !in_ready)
    else $error("input taken during record readout");
`endif

endmodule
